// ===== sv/lsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, codes and helpers for the launch sequence controller.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int TIME_BITS   = 32;   // internal timestamp width, 8..64
    localparam int PORT_TIME_W = 32;
    localparam int TOUT_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CMP_W       = 64;

    // flight phases
    localparam logic [2:0] PH_SAFE   = 3'd0;
    localparam logic [2:0] PH_ARMED  = 3'd1;
    localparam logic [2:0] PH_IGN    = 3'd2;
    localparam logic [2:0] PH_BUILD  = 3'd3;
    localparam logic [2:0] PH_ASCENT = 3'd4;
    localparam logic [2:0] PH_ABORT  = 3'd5;

    // fault codes
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_BACK  = 3'd1;
    localparam logic [2:0] FLT_STALL = 3'd2;
    localparam logic [2:0] FLT_IGN   = 3'd3;
    localparam logic [2:0] FLT_LIFT  = 3'd4;
    localparam logic [2:0] FLT_SHUT  = 3'd5;

    // operator commands
    localparam logic [1:0] FN_NONE   = 2'd0;
    localparam logic [1:0] FN_ARM    = 2'd1;
    localparam logic [1:0] FN_LAUNCH = 2'd2;

    // command verdicts
    localparam logic [1:0] VD_NONE = 2'd0;
    localparam logic [1:0] VD_ACC  = 2'd1;
    localparam logic [1:0] VD_REJ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IGN_TIMEOUT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_TIMEOUT = CFG_IDX_W'(1);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_time      now;
        logic [1:0] func;
        logic       running;
        logic       liftoff;
    } t_item;

    typedef struct packed {
        logic [2:0] phase;
        logic       drive;
        logic [2:0] fault;
        logic [1:0] verdict;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] fault;
        t_time      last_time;
        logic       have_last;
        t_time      ign_start;
        t_time      build_start;
    } t_state;

    typedef struct packed {
        logic [TOUT_W-1:0] ign_timeout;
        logic [TOUT_W-1:0] lift_timeout;
    } t_cfg;

    // port timestamp to internal width (zero extend or truncate)
    function automatic t_time port_to_time(input logic [PORT_TIME_W-1:0] x);
        logic [CMP_W-1:0] w;
        w = '0;
        w[PORT_TIME_W-1:0] = x;
        return w[TIME_BITS-1:0];
    endfunction

    // elapsed <= timeout, both taken unsigned
    function automatic logic elapsed_le(input t_time el, input logic [TOUT_W-1:0] tout);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = '0;
        b = '0;
        a[TIME_BITS-1:0] = el;
        b[TOUT_W-1:0]    = tout;
        return a <= b;
    endfunction

    function automatic logic elapsed_ge(input t_time el, input logic [TOUT_W-1:0] tout);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = '0;
        b = '0;
        a[TIME_BITS-1:0] = el;
        b[TOUT_W-1:0]    = tout;
        return a >= b;
    endfunction

endpackage

// ===== sv/lsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_cfg_regs
// Timeout registers written over the configuration channel.
// ----------------------------------------------------------------------------
module lsc_cfg_regs
    import lsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IGN_TIMEOUT:  r_cfg.ign_timeout  <= TOUT_W'(i_cfg_data);
                REG_LIFT_TIMEOUT: r_cfg.lift_timeout <= TOUT_W'(i_cfg_data);
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

// ===== sv/lsc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_step
// Flight state registers and the one-update transition logic.
// ----------------------------------------------------------------------------
module lsc_step
    import lsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_state r_state;
    t_state n_state;
    logic [1:0] verdict;
    t_time      ign_elapsed;
    t_time      build_elapsed;

    assign ign_elapsed   = i_item.now - r_state.ign_start;
    assign build_elapsed = i_item.now - r_state.build_start;

    always_comb begin
        n_state = r_state;
        verdict = VD_NONE;
        if (r_state.phase == PH_ABORT) begin
            verdict = (i_item.func != FN_NONE) ? VD_REJ : VD_NONE;
        end else if (r_state.have_last && (i_item.now < r_state.last_time)) begin
            n_state.phase = PH_ABORT;
            n_state.fault = FLT_BACK;
        end else if (r_state.have_last && (i_item.now == r_state.last_time)) begin
            n_state.phase = PH_ABORT;
            n_state.fault = FLT_STALL;
        end else begin
            n_state.last_time = i_item.now;
            n_state.have_last = 1'b1;
            case (r_state.phase)
                PH_SAFE: begin
                    if (i_item.func == FN_ARM) begin
                        n_state.phase = PH_ARMED;
                        verdict       = VD_ACC;
                    end else if (i_item.func == FN_LAUNCH) begin
                        verdict = VD_REJ;
                    end
                end
                PH_ARMED: begin
                    if (i_item.func == FN_LAUNCH) begin
                        n_state.phase     = PH_IGN;
                        n_state.ign_start = i_item.now;
                        verdict           = VD_ACC;
                    end else if (i_item.func == FN_ARM) begin
                        verdict = VD_REJ;
                    end
                end
                PH_IGN: begin
                    if (i_item.func != FN_NONE) verdict = VD_REJ;
                    if (i_item.running && elapsed_le(ign_elapsed, i_cfg.ign_timeout)) begin
                        n_state.phase       = PH_BUILD;
                        n_state.build_start = i_item.now;
                    end else if (elapsed_ge(ign_elapsed, i_cfg.ign_timeout)) begin
                        n_state.phase = PH_ABORT;
                        n_state.fault = FLT_IGN;
                    end
                end
                PH_BUILD: begin
                    if (i_item.func != FN_NONE) verdict = VD_REJ;
                    // engine loss wins over the liftoff window
                    if (!i_item.running) begin
                        n_state.phase = PH_ABORT;
                        n_state.fault = FLT_SHUT;
                    end else if (i_item.liftoff &&
                                 elapsed_le(build_elapsed, i_cfg.lift_timeout)) begin
                        n_state.phase = PH_ASCENT;
                    end else if (elapsed_ge(build_elapsed, i_cfg.lift_timeout)) begin
                        n_state.phase = PH_ABORT;
                        n_state.fault = FLT_LIFT;
                    end
                end
                PH_ASCENT: begin
                    if (i_item.func != FN_NONE) verdict = VD_REJ;
                    if (!i_item.running) begin
                        n_state.phase = PH_ABORT;
                        n_state.fault = FLT_SHUT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.phase   = n_state.phase;
        o_result.drive   = (n_state.phase == PH_IGN) || (n_state.phase == PH_BUILD) ||
                           (n_state.phase == PH_ASCENT);
        o_result.fault   = n_state.fault;
        o_result.verdict = verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_SAFE;
            r_state.fault       <= FLT_NONE;
            r_state.last_time   <= '0;
            r_state.have_last   <= 1'b0;
            r_state.ign_start   <= '0;
            r_state.build_start <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/launch_sequence_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// launch_sequence_controller
// Launch sequencer: phase flow, timeouts, sticky abort with latched fault.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one update: timestamp,
//   operator command and the two engine flags. Output channel (o_out_valid /
//   i_out_ready) returns one result per update: phase, ignition drive,
//   latched fault and command verdict, in update order.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the
//   ignition and liftoff timeouts; index 0 and 1, other indexes ignored.
//   Write them only while no update is in flight.
//   An accepted update passes the input register, then the result register.
//   Throughput: one update per cycle while results are taken; the transition
//   logic between the two registers is a single subtract-and-compare pass.
//   A stalled receiver holds the result register; the input register still
//   takes one more update, after which o_in_ready drops until the result
//   is transferred.
//   Reset (i_rst_n low, synchronous) returns to safe with no fault, clears
//   the timestamp history, the timeouts and empties both pipeline stages.
// ----------------------------------------------------------------------------
module launch_sequence_controller
    import lsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [PORT_TIME_W-1:0] i_current_time,
    input  logic [1:0]             i_func,
    input  logic                   i_engine_running,
    input  logic                   i_liftoff_detected,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_flight_phase,
    output logic                   o_ignition_drive,
    output logic [2:0]             o_fault_code,
    output logic [1:0]             o_command_verdict,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result step_result;
    t_cfg    cfg;
    logic    fire;

    // advance when the result register is free or being emptied
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    lsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    lsc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.now     <= port_to_time(i_current_time);
            r_item.func    <= i_func;
            r_item.running <= i_engine_running;
            r_item.liftoff <= i_liftoff_detected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_flight_phase    = r_result.phase;
    assign o_ignition_drive  = r_result.drive;
    assign o_fault_code      = r_result.fault;
    assign o_command_verdict = r_result.verdict;

endmodule

// ===== sv/lsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the launch sequence controller results.
// ----------------------------------------------------------------------------
module lsc_checker
    import lsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_flight_phase,
    input logic       o_ignition_drive,
    input logic [2:0] o_fault_code,
    input logic [1:0] o_command_verdict
);

    // drive follows the flying phases
    a_drive_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ignition_drive ==
            ((o_flight_phase == PH_IGN) || (o_flight_phase == PH_BUILD) ||
             (o_flight_phase == PH_ASCENT))))
        else $error("ignition drive disagrees with phase");

    // a latched fault appears exactly with the abort phase
    a_fault_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_fault_code != FLT_NONE) == (o_flight_phase == PH_ABORT)))
        else $error("fault code and abort phase out of step");

    // aborted result never accepts a command
    a_abort_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_flight_phase == PH_ABORT)) |-> (o_command_verdict != VD_ACC))
        else $error("command accepted in abort");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_flight_phase) && $stable(o_fault_code) &&
             $stable(o_command_verdict)))
        else $error("result changed while stalled");

endmodule

bind launch_sequence_controller lsc_checker u_lsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_flight_phase    (o_flight_phase),
    .o_ignition_drive  (o_ignition_drive),
    .o_fault_code      (o_fault_code),
    .o_command_verdict (o_command_verdict)
);

// ===== test/tb_launch_sequence_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_launch_sequence_controller
// Self-checking bench for the launch sequencer. A scoreboard keeps its own
// copy of the flight state and timeouts, predicts one report per update and
// compares every returned report field by field, in order. Stimulus walks
// safe, armed and ignition, then buildup and ascent as the abort plan needs,
// with random content and random idling on both channels, then ends the
// flight with one abort picked at random and keeps feeding the latched abort.
// ----------------------------------------------------------------------------
module tb_launch_sequence_controller;
    import lsc_pkg::*;

    localparam int          CYCLE_LIMIT   = 500_000;
    localparam int          TOTAL_UPDATES = 1450;
    localparam int          FLIGHT_BUDGET = 900;     // updates spent in flying phases
    localparam int unsigned BIG_STEP      = 1 << 20;
    localparam int          DRAIN_CYCLES  = 16;
    localparam logic [1:0]  FN_UNKNOWN    = 2'd3;

    typedef enum int {
        PLAN_IGN_TIMEOUT,
        PLAN_LIFT_TIMEOUT,
        PLAN_SHUT_BUILDUP,
        PLAN_SHUT_ASCENT,
        PLAN_TIME_BACK,
        PLAN_TIME_STALL
    } t_abort_plan;

    // ------------------------------------------------------------------------
    // Scoreboard: predicted flight state and the reports still owed
    // ------------------------------------------------------------------------
    class flight_scoreboard;
        t_result           pending_reports[$];
        int                mismatches;
        logic [2:0]        phase_now;
        logic [2:0]        fault_latched;
        t_time             last_stamp;
        bit                stamp_seen;
        t_time             ign_t0;
        t_time             build_t0;
        logic [TOUT_W-1:0] ign_limit;
        logic [TOUT_W-1:0] lift_limit;

        function new();
            pending_reports.delete();
            mismatches    = 0;
            phase_now     = PH_SAFE;
            fault_latched = FLT_NONE;
            last_stamp    = '0;
            stamp_seen    = 1'b0;
            ign_t0        = '0;
            build_t0      = '0;
            ign_limit     = '0;
            lift_limit    = '0;
        endfunction

        function void write_limit(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IGN_TIMEOUT)
                ign_limit = TOUT_W'(val);
            else if (idx == REG_LIFT_TIMEOUT)
                lift_limit = TOUT_W'(val);
        endfunction

        function void log_update(input t_item it);
            t_result    r;
            t_time      el;
            logic [1:0] verdict;
            verdict = VD_NONE;
            if (phase_now == PH_ABORT) begin
                // latched: nothing moves, timestamp not looked at
                if (it.func != FN_NONE)
                    verdict = VD_REJ;
            end else if (stamp_seen && it.now <= last_stamp) begin
                fault_latched = (it.now < last_stamp) ? FLT_BACK : FLT_STALL;
                phase_now     = PH_ABORT;
            end else begin
                last_stamp = it.now;
                stamp_seen = 1'b1;
                case (phase_now)
                    PH_SAFE: begin
                        if (it.func == FN_ARM) begin
                            phase_now = PH_ARMED;
                            verdict   = VD_ACC;
                        end else if (it.func == FN_LAUNCH) begin
                            verdict = VD_REJ;
                        end
                    end
                    PH_ARMED: begin
                        if (it.func == FN_LAUNCH) begin
                            phase_now = PH_IGN;
                            ign_t0    = it.now;
                            verdict   = VD_ACC;
                        end else if (it.func == FN_ARM) begin
                            verdict = VD_REJ;
                        end
                    end
                    PH_IGN: begin
                        if (it.func != FN_NONE)
                            verdict = VD_REJ;
                        el = it.now - ign_t0;
                        if (it.running && 64'(el) <= 64'(ign_limit)) begin
                            phase_now = PH_BUILD;
                            build_t0  = it.now;
                        end else if (64'(el) >= 64'(ign_limit)) begin
                            phase_now     = PH_ABORT;
                            fault_latched = FLT_IGN;
                        end
                    end
                    PH_BUILD: begin
                        if (it.func != FN_NONE)
                            verdict = VD_REJ;
                        el = it.now - build_t0;
                        if (!it.running) begin
                            phase_now     = PH_ABORT;
                            fault_latched = FLT_SHUT;
                        end else if (it.liftoff && 64'(el) <= 64'(lift_limit)) begin
                            phase_now = PH_ASCENT;
                        end else if (64'(el) >= 64'(lift_limit)) begin
                            phase_now     = PH_ABORT;
                            fault_latched = FLT_LIFT;
                        end
                    end
                    PH_ASCENT: begin
                        if (it.func != FN_NONE)
                            verdict = VD_REJ;
                        if (!it.running) begin
                            phase_now     = PH_ABORT;
                            fault_latched = FLT_SHUT;
                        end
                    end
                    default: ;
                endcase
            end
            r.phase   = phase_now;
            r.drive   = (phase_now == PH_IGN) || (phase_now == PH_BUILD) ||
                        (phase_now == PH_ASCENT);
            r.fault   = fault_latched;
            r.verdict = verdict;
            pending_reports.push_back(r);
        endfunction

        function void flag(input string msg);
            mismatches++;
            $display("%s", msg);
        endfunction

        function void check_report(input t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                flag($sformatf("%0t: report arrived with no update pending", $time));
                return;
            end
            want = pending_reports.pop_front();
            if (got.phase !== want.phase)
                flag($sformatf("%0t: flight_phase expected %0d, got %0d",
                               $time, want.phase, got.phase));
            if (got.drive !== want.drive)
                flag($sformatf("%0t: ignition_drive expected %0d, got %0d",
                               $time, want.drive, got.drive));
            if (got.fault !== want.fault)
                flag($sformatf("%0t: fault_code expected %0d, got %0d",
                               $time, want.fault, got.fault));
            if (got.verdict !== want.verdict)
                flag($sformatf("%0t: command_verdict expected %0d, got %0d",
                               $time, want.verdict, got.verdict));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                   i_clk              = 1'b0;
    logic                   i_rst_n            = 1'b0;
    logic                   i_in_valid         = 1'b0;
    logic                   o_in_ready;
    logic [PORT_TIME_W-1:0] i_current_time     = '0;
    logic [1:0]             i_func             = FN_NONE;
    logic                   i_engine_running   = 1'b0;
    logic                   i_liftoff_detected = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready        = 1'b0;
    logic [2:0]             o_flight_phase;
    logic                   o_ignition_drive;
    logic [2:0]             o_fault_code;
    logic [1:0]             o_command_verdict;
    logic                   i_cfg_valid        = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index        = REG_IGN_TIMEOUT;
    logic [CFG_DATA_W-1:0]  i_cfg_data         = '0;

    flight_scoreboard flight;
    t_time            mission_clock;
    int               n_updates   = 0;
    int               cycle_count = 0;
    bit               tx_steady   = 1'b0;
    bit               rx_steady   = 1'b0;
    logic             rx_block    = 1'b0;

    launch_sequence_controller u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_current_time     (i_current_time),
        .i_func             (i_func),
        .i_engine_running   (i_engine_running),
        .i_liftoff_detected (i_liftoff_detected),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_flight_phase     (o_flight_phase),
        .o_ignition_drive   (o_ignition_drive),
        .o_fault_code       (o_fault_code),
        .o_command_verdict  (o_command_verdict),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    task automatic send_update(input t_time stamp_in, input logic [1:0] fn,
                               input logic run, input logic lift);
        int    gap;
        t_item it;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_current_time     <= PORT_TIME_W'(stamp_in);
        i_func             <= fn;
        i_engine_running   <= run;
        i_liftoff_detected <= lift;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        it.now     = stamp_in;
        it.func    = fn;
        it.running = run;
        it.liftoff = lift;
        flight.log_update(it);
        n_updates++;
    endtask

    task automatic tick_send(input int unsigned dt, input logic [1:0] fn,
                             input logic run, input logic lift);
        mission_clock += dt;
        send_update(mission_clock, fn, run, lift);
    endtask

    // sender holds off until every owed report is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (flight.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        flight.write_limit(idx, val);
    endtask

    task automatic hold_receiver(input int cycles);
        fork
            begin
                rx_block <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                rx_block <= 1'b0;
            end
        join_none
    endtask

    task automatic drain_results();
        int      stall;
        t_result got;
        forever begin
            if (rx_block) begin
                i_out_ready <= 1'b0;
                while (rx_block) @(posedge i_clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.phase   = o_flight_phase;
            got.drive   = o_ignition_drive;
            got.fault   = o_fault_code;
            got.verdict = o_command_verdict;
            flight.check_report(got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Flight scenarios
    // ------------------------------------------------------------------------
    function automatic int unsigned next_step();
        if ($urandom_range(0, 49) == 0)
            return $urandom_range(1, BIG_STEP);
        return $urandom_range(1, 1000);
    endfunction

    // Hold the current flying phase; the phase timeout is raised before each
    // batch so it cannot expire inside the batch.
    task automatic dwell(input int count);
        int                left;
        int                batch;
        t_time             el;
        logic [TOUT_W-1:0] lim;
        logic              run;
        logic              lift;
        left = count;
        while (left > 0) begin
            batch = $urandom_range(20, 60);
            if (batch > left)
                batch = left;
            lim = TOUT_W'(batch) * BIG_STEP + $urandom_range(1, 5000);
            case (flight.phase_now)
                PH_IGN: begin
                    el = mission_clock - flight.ign_t0;
                    write_reg(REG_IGN_TIMEOUT, TOUT_W'(el) + lim);
                end
                PH_BUILD: begin
                    el = mission_clock - flight.build_t0;
                    write_reg(REG_LIFT_TIMEOUT, TOUT_W'(el) + lim);
                end
                default: begin
                    // no timeout in ascent, just vary the settings
                    write_reg(($urandom_range(0, 1) == 0) ? REG_IGN_TIMEOUT :
                              REG_LIFT_TIMEOUT, $urandom);
                end
            endcase
            repeat (batch) begin
                run  = (flight.phase_now != PH_IGN);
                lift = (flight.phase_now == PH_BUILD) ? 1'b0 : 1'(($urandom_range(0, 1)));
                tick_send(next_step(), 2'($urandom_range(0, 3)), run, lift);
            end
            left -= batch;
        end
    endtask

    // Leave ignition or buildup, either onward or into a timeout abort.
    // The limit is set against the elapsed time of the closing update.
    task automatic close_phase(input bit time_out);
        int unsigned       dt;
        int                how;
        t_time             el;
        logic [TOUT_W-1:0] lim;
        logic              run;
        logic              lift;
        dt   = $urandom_range(1, 1000);
        how  = $urandom_range(0, 2);
        run  = 1'b1;
        lift = 1'b1;
        if (flight.phase_now == PH_IGN) begin
            el   = mission_clock + dt - flight.ign_t0;
            lift = 1'($urandom_range(0, 1));
        end else begin
            el = mission_clock + dt - flight.build_t0;
        end
        if (!time_out) begin
            // exact boundary still passes
            lim = (how == 0) ? TOUT_W'(el) : TOUT_W'(el) + $urandom_range(1, 1000);
        end else if (how == 0) begin
            // elapsed lands on the limit without the awaited event
            lim = TOUT_W'(el);
            if (flight.phase_now == PH_IGN)
                run = 1'b0;
            else
                lift = 1'b0;
        end else if (how == 1) begin
            // event comes, but too late
            lim = TOUT_W'(el) - TOUT_W'($urandom_range(1, el));
        end else begin
            lim = '0;
        end
        write_reg((flight.phase_now == PH_IGN) ? REG_IGN_TIMEOUT : REG_LIFT_TIMEOUT, lim);
        tick_send(dt, 2'($urandom_range(0, 3)), run, lift);
    endtask

    task automatic skew_clock(input bit stalled);
        t_time bad;
        bad = stalled ? mission_clock : t_time'($urandom_range(0, mission_clock - 1));
        send_update(bad, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_abort_plan plan;
        int          stages;
        int          k;
        int          pick;
        logic [1:0]  fn;

        flight = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        plan = t_abort_plan'($urandom_range(0, 5));
        case (plan)
            PLAN_IGN_TIMEOUT:                    stages = 1;
            PLAN_LIFT_TIMEOUT, PLAN_SHUT_BUILDUP: stages = 2;
            PLAN_SHUT_ASCENT:                    stages = 3;
            default:                             stages = $urandom_range(1, 3);
        endcase

        write_reg(REG_IGN_TIMEOUT, '1);
        write_reg(REG_LIFT_TIMEOUT, '1);

        // safe: first stamp zero, unknown command ignored, launch refused
        mission_clock = '0;
        send_update(mission_clock, FN_NONE, 1'b0, 1'b0);
        tick_send(1, FN_UNKNOWN, 1'b1, 1'b1);
        tick_send(1, FN_LAUNCH, 1'b0, 1'b1);

        // long receiver stall while updates keep coming, to back up the pipe
        hold_receiver(80);
        tx_steady = 1'b1;
        repeat (20) begin
            pick = $urandom_range(0, 2);
            fn   = (pick == 0) ? FN_NONE : (pick == 1) ? FN_LAUNCH : FN_UNKNOWN;
            tick_send(next_step(), fn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        tick_send(1, FN_ARM, 1'b1, 1'b0);

        // armed: unknown ignored, second arm refused
        tick_send(1, FN_UNKNOWN, 1'b0, 1'b1);
        tick_send(1, FN_ARM, 1'b1, 1'b1);
        repeat (20) begin
            pick = $urandom_range(0, 2);
            fn   = (pick == 0) ? FN_NONE : (pick == 1) ? FN_ARM : FN_UNKNOWN;
            tick_send(next_step(), fn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        tick_send(1, FN_LAUNCH, 1'b0, 1'b0);

        // ignition: every command refused
        tick_send(1, FN_ARM, 1'b0, 1'b0);
        tick_send(1, FN_LAUNCH, 1'b0, 1'b1);
        tick_send(1, FN_UNKNOWN, 1'b0, 1'b1);

        for (k = 1; k <= stages; k++) begin
            dwell(FLIGHT_BUDGET / stages);
            if (k < stages) begin
                close_phase(1'b0);
            end else begin
                case (plan)
                    PLAN_IGN_TIMEOUT, PLAN_LIFT_TIMEOUT: close_phase(1'b1);
                    PLAN_SHUT_BUILDUP, PLAN_SHUT_ASCENT:
                        tick_send(next_step(), 2'($urandom_range(0, 3)), 1'b0,
                                  1'($urandom_range(0, 1)));
                    PLAN_TIME_BACK:  skew_clock(1'b0);
                    default:         skew_clock(1'b1);
                endcase
            end
        end

        // aborted: latched whatever comes, verdict only reflects the command
        send_update('1, FN_NONE, 1'b1, 1'b1);
        send_update('0, FN_ARM, 1'b0, 1'b0);
        send_update(mission_clock, FN_LAUNCH, 1'b1, 1'b0);
        send_update(t_time'($urandom), FN_UNKNOWN, 1'b0, 1'b1);
        write_reg(REG_IGN_TIMEOUT, '0);
        write_reg(REG_LIFT_TIMEOUT, '0);
        while (n_updates < TOTAL_UPDATES) begin
            if ($urandom_range(0, 99) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_IGN_TIMEOUT :
                          REG_LIFT_TIMEOUT, $urandom);
            send_update(t_time'($urandom), 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (flight.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (flight.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lsc_pkg.sv
sv/lsc_cfg_regs.sv
sv/lsc_step.sv
sv/launch_sequence_controller.sv
sv/lsc_checker.sv
test/tb_launch_sequence_controller.sv
